[rtl/core/pcvx_pkg.sv]
// ----------------------------------------------------------------------------
// pcvx_pkg: shared types and helpers for the polygon convexity/area core
// Widths, limits and turn sign codes for the front and accumulate stages,
// and the exact integer cross product used by the front stage.
// ----------------------------------------------------------------------------
package pcvx_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MULT_W  = 2 * DIFF_W;
  localparam int PROD_W  = MULT_W + 1;
  localparam int AREA_W  = 45;
  localparam int SUM_W   = AREA_W + 1;
  localparam int DA_W    = 44;
  localparam int COUNT_W = 11;

  // Vertex limit; beyond it vertices are dropped and overflow is flagged
  localparam int MAX_VERTICES = 1024;
  localparam logic [COUNT_W-1:0] VTX_LIMIT = COUNT_W'(MAX_VERTICES);
  localparam logic [COUNT_W-1:0] VTX_SAT   = COUNT_W'(MAX_VERTICES + 1);
  localparam logic [COUNT_W-1:0] VTX_TRI   = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] VTX_TWO   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] VTX_ONE   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] VTX_NONE  = '0;

  // Area saturation bound, +/-(2^44 - 1)
  localparam logic signed [SUM_W-1:0] AREA_MAX = {{(SUM_W-DA_W){1'b0}}, {DA_W{1'b1}}};
  localparam logic signed [SUM_W-1:0] AREA_MIN = -AREA_MAX;

  // Turn sign codes
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd3;

  // One vertex worth of products, handed from the front to the accumulator
  typedef struct packed {
    logic signed [PROD_W-1:0] term;        // fan cross product, zero if none
    logic                     turn_valid;  // a turn was taken at this vertex
    logic                     first_turn;  // it sets the reference sign
    logic [1:0]               turn_sign;
    logic                     close_check; // closing turns count (last only)
    logic [1:0]               close_sign_a;
    logic [1:0]               close_sign_b;
    logic                     last;
    logic [COUNT_W-1:0]       count;       // vertices so far, saturated
  } pcvx_step_t;

  // Difference of two coordinates, one bit wider
  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] wa;
    logic signed [DIFF_W-1:0] wb;
    wa = DIFF_W'(a);
    wb = DIFF_W'(b);
    return wa - wb;
  endfunction

  // (dx1, dy1) x (dx2, dy2), exact
  function automatic logic signed [PROD_W-1:0] cross_diff(
    input logic signed [DIFF_W-1:0] dx1,
    input logic signed [DIFF_W-1:0] dy1,
    input logic signed [DIFF_W-1:0] dx2,
    input logic signed [DIFF_W-1:0] dy2
  );
    logic signed [MULT_W-1:0] p1;
    logic signed [MULT_W-1:0] p2;
    p1 = dx1 * dy2;
    p2 = dy1 * dx2;
    return PROD_W'(p1) - PROD_W'(p2);
  endfunction

  // Turn at b going a -> b -> c
  function automatic logic signed [PROD_W-1:0] turn_cross(
    input logic signed [COORD_W-1:0] ax,
    input logic signed [COORD_W-1:0] ay,
    input logic signed [COORD_W-1:0] bx,
    input logic signed [COORD_W-1:0] by,
    input logic signed [COORD_W-1:0] cx,
    input logic signed [COORD_W-1:0] cy
  );
    return cross_diff(coord_diff(bx, ax), coord_diff(by, ay),
                      coord_diff(cx, bx), coord_diff(cy, by));
  endfunction

  function automatic logic [1:0] sign_code(input logic signed [PROD_W-1:0] t);
    logic [1:0] s;
    priority if (t == '0) begin
      s = SIGN_ZERO;
    end else if (t[PROD_W-1]) begin
      s = SIGN_NEG;
    end else begin
      s = SIGN_POS;
    end
    return s;
  endfunction

endpackage

[rtl/core/pcvx_front.sv]
// ----------------------------------------------------------------------------
// pcvx_front: input register, vertex history and cross products
// Holds the first, second, previous and before-previous vertices and the
// vertex count, and registers the fan term and turn signs of each vertex.
// ----------------------------------------------------------------------------
module pcvx_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [pcvx_pkg::COORD_W-1:0]   x_coord,
  input  logic signed [pcvx_pkg::COORD_W-1:0]   y_coord,
  input  logic                                  last_vertex,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  output logic                                  step_valid,
  output pcvx_pkg::pcvx_step_t                  step,
  input  logic                                  step_take
);
  import pcvx_pkg::*;

  // Input register
  logic                      s0_valid;
  logic signed [COORD_W-1:0] s0_x;
  logic signed [COORD_W-1:0] s0_y;
  logic                      s0_last;

  // Vertex history and count
  logic signed [COORD_W-1:0] fst_x, fst_y, snd_x, snd_y;
  logic signed [COORD_W-1:0] prv_x, prv_y, bpr_x, bpr_y;
  logic [COUNT_W-1:0]        count;

  logic signed [COORD_W-1:0] fst_x_next, fst_y_next, snd_x_next, snd_y_next;
  logic signed [COORD_W-1:0] prv_x_next, prv_y_next, bpr_x_next, bpr_y_next;
  logic [COUNT_W-1:0]        count_next;
  logic [COUNT_W-1:0]        accepted;

  logic       s0_take;
  logic       in_take;
  logic       active;
  pcvx_step_t step_next;

  // Handshake
  assign s0_take  = s0_valid && (!step_valid || step_take);
  assign in_stall = s0_valid && !s0_take;
  assign in_take  = in_valid && !in_stall;

  // History update for the vertex in the input register
  always_comb begin
    active     = (count < VTX_LIMIT);
    fst_x_next = fst_x;
    fst_y_next = fst_y;
    snd_x_next = snd_x;
    snd_y_next = snd_y;
    prv_x_next = prv_x;
    prv_y_next = prv_y;
    bpr_x_next = bpr_x;
    bpr_y_next = bpr_y;
    if (active) begin
      if (count == VTX_NONE) begin
        fst_x_next = s0_x;
        fst_y_next = s0_y;
      end
      if (count == VTX_ONE) begin
        snd_x_next = s0_x;
        snd_y_next = s0_y;
      end
      bpr_x_next = prv_x;
      bpr_y_next = prv_y;
      prv_x_next = s0_x;
      prv_y_next = s0_y;
    end
    count_next = (count < VTX_SAT) ? count + VTX_ONE : count;
    accepted   = (count_next > VTX_LIMIT) ? VTX_LIMIT : count_next;
  end

  // Products: fan term, turn at the previous vertex, two closing turns
  always_comb begin
    step_next.turn_valid = active && (count >= VTX_TWO);
    step_next.first_turn = (count == VTX_TWO);
    step_next.term       = step_next.turn_valid ?
      cross_diff(coord_diff(prv_x, fst_x), coord_diff(prv_y, fst_y),
                 coord_diff(s0_x, fst_x), coord_diff(s0_y, fst_y)) : '0;
    step_next.turn_sign  = sign_code(turn_cross(bpr_x, bpr_y, prv_x, prv_y,
                                                s0_x, s0_y));
    step_next.close_check  = s0_last && (accepted > VTX_TRI);
    step_next.close_sign_a = sign_code(turn_cross(bpr_x_next, bpr_y_next,
                                                  prv_x_next, prv_y_next,
                                                  fst_x_next, fst_y_next));
    step_next.close_sign_b = sign_code(turn_cross(prv_x_next, prv_y_next,
                                                  fst_x_next, fst_y_next,
                                                  snd_x_next, snd_y_next));
    step_next.last  = s0_last;
    step_next.count = count_next;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_take) begin
      s0_valid <= 1'b1;
    end else if (s0_take) begin
      s0_valid <= 1'b0;
    end
    if (in_take) begin
      s0_x    <= x_coord;
      s0_y    <= y_coord;
      s0_last <= last_vertex;
    end
  end

  // History; cleared after the closing vertex
  always_ff @(posedge clk) begin
    if (rst || (s0_take && s0_last)) begin
      fst_x <= '0;
      fst_y <= '0;
      snd_x <= '0;
      snd_y <= '0;
      prv_x <= '0;
      prv_y <= '0;
      bpr_x <= '0;
      bpr_y <= '0;
      count <= '0;
    end else if (s0_take) begin
      fst_x <= fst_x_next;
      fst_y <= fst_y_next;
      snd_x <= snd_x_next;
      snd_y <= snd_y_next;
      prv_x <= prv_x_next;
      prv_y <= prv_y_next;
      bpr_x <= bpr_x_next;
      bpr_y <= bpr_y_next;
      count <= count_next;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (s0_take) begin
      step_valid <= 1'b1;
    end else if (step_take) begin
      step_valid <= 1'b0;
    end
    if (s0_take) begin
      step <= step_next;
    end
  end

endmodule

[rtl/core/polygon_convexity_and_area_core.sv]
// ----------------------------------------------------------------------------
// polygon_convexity_and_area_core: streaming doubled area and convexity test
// The last vertex passes the input, product and result registers in order.
// Throughput: one vertex per cycle unless stalled (area add/saturate loop).
// Reset: rst clears all pipeline valids, vertex history and sums.
// State returns to its reset values after every result.
// ----------------------------------------------------------------------------
module polygon_convexity_and_area_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [pcvx_pkg::COORD_W-1:0]   x_coord,
  input  logic signed [pcvx_pkg::COORD_W-1:0]   y_coord,
  input  logic                                  last_vertex,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  output logic [pcvx_pkg::DA_W-1:0]             doubled_area,
  output logic                                  is_convex,
  output logic [pcvx_pkg::COUNT_W-1:0]          vertex_total,
  output logic                                  overflow,
  output logic                                  out_valid,
  input  logic                                  out_stall
);
  import pcvx_pkg::*;

  logic       step_valid;
  pcvx_step_t step;
  logic       step_take;
  logic       out_free;

  // Accumulator state
  logic signed [AREA_W-1:0] area_sum;
  logic [1:0]               ref_sign;
  logic                     signs_agree;

  logic signed [SUM_W-1:0]  sum_raw;
  logic signed [AREA_W-1:0] area_sum_next;
  logic [1:0]               ref_sign_next;
  logic                     signs_agree_next;
  logic [SUM_W-1:0]         area_abs;
  logic                     convex_next;
  logic [COUNT_W-1:0]       accepted;

  pcvx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .last_vertex (last_vertex),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .step_valid  (step_valid),
    .step        (step),
    .step_take   (step_take)
  );

  // A closing vertex needs a free result register
  assign out_free  = !out_valid || !out_stall;
  assign step_take = step_valid && (!step.last || out_free);

  // Area accumulate with saturation, turn sign agreement
  always_comb begin
    sum_raw = SUM_W'(area_sum) + SUM_W'(step.term);
    priority if (sum_raw > AREA_MAX) begin
      area_sum_next = AREA_W'(AREA_MAX);
    end else if (sum_raw < AREA_MIN) begin
      area_sum_next = AREA_W'(AREA_MIN);
    end else begin
      area_sum_next = AREA_W'(sum_raw);
    end

    ref_sign_next    = ref_sign;
    signs_agree_next = signs_agree;
    if (step.turn_valid) begin
      if (step.first_turn) begin
        ref_sign_next = step.turn_sign;
      end else if (step.turn_sign != ref_sign) begin
        signs_agree_next = 1'b0;
      end
    end

    accepted    = (step.count > VTX_LIMIT) ? VTX_LIMIT : step.count;
    convex_next = (accepted <= VTX_TRI) ||
                  (signs_agree_next &&
                   (!step.close_check ||
                    ((step.close_sign_a == ref_sign_next) &&
                     (step.close_sign_b == ref_sign_next))));
    area_abs    = area_sum_next[AREA_W-1] ? SUM_W'(-SUM_W'(area_sum_next))
                                          : SUM_W'(area_sum_next);
  end

  // Accumulator registers; cleared after the closing vertex
  always_ff @(posedge clk) begin
    if (rst || (step_take && step.last)) begin
      area_sum    <= '0;
      ref_sign    <= SIGN_ZERO;
      signs_agree <= 1'b1;
    end else if (step_take) begin
      area_sum    <= area_sum_next;
      ref_sign    <= ref_sign_next;
      signs_agree <= signs_agree_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_take && step.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (step_take && step.last) begin
      doubled_area <= area_abs[DA_W-1:0];
      is_convex    <= convex_next;
      vertex_total <= step.count;
      overflow     <= (step.count > VTX_LIMIT);
    end
  end

  // Checks
  a_overflow_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (overflow == (vertex_total == VTX_SAT)))
    else $error("overflow flag disagrees with vertex total");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (vertex_total != VTX_NONE))
    else $error("result with no vertices");

  a_small_convex: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (vertex_total <= VTX_TRI)) |-> is_convex)
    else $error("polygon of three or fewer vertices reported non-convex");

  a_small_area: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (vertex_total <= VTX_TWO)) |-> (doubled_area == '0))
    else $error("degenerate polygon reported nonzero area");

endmodule
